FILE: sv/bbl_pkg.sv
package bbl_pkg;

  localparam logic [2:0] MODE_LOOKUP = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_STATS  = 3'd3;
  localparam logic [2:0] MODE_TRIM   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LK_SCAN,
    S_LK_UPD,
    S_INS_SCAN,
    S_INS_DROP,
    S_INS_DEC,
    S_FREE_SCAN,
    S_STORE,
    S_TRIM_CHK,
    S_EV_SCAN,
    S_EV_DEC,
    S_EV_EMIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    G_ALL,
    G_FULL,
    G_TRIM
  } goal_t;

  typedef struct packed {
    logic latch_req;
    logic scan;
    logic lk_upd;
    logic drop_match;
    logic evict;
    logic store;
    logic clear_all;
    logic clr_stats;
    logic emit_done;
    logic emit_evict;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       scan_last;
    logic       req_invalid;
    logic       item_over;
    logic       over_budget;
    logic       full;
    logic       ffound;
    logic       ofound;
    logic       out_free;
  } ctrl_sts_t;

endpackage

FILE: sv/bbl_ctrl.sv
module bbl_ctrl
  import bbl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  goal_t  goal_r, goal_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      goal_r  <= G_ALL;
    end else begin
      state_r <= state_nxt;
      goal_r  <= goal_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    goal_nxt  = goal_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_LOOKUP: state_nxt = S_LK_SCAN;
          MODE_INSERT: state_nxt = sts.req_invalid ? S_DONE : S_INS_SCAN;
          MODE_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_nxt     = S_DONE;
          end
          MODE_STATS: begin
            cmd.clr_stats = 1'b1;
            state_nxt     = S_DONE;
          end
          MODE_TRIM: state_nxt = S_TRIM_CHK;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_LK_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_LK_UPD;
      end
      S_LK_UPD: begin
        cmd.lk_upd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_INS_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_INS_DROP;
      end
      S_INS_DROP: begin
        cmd.drop_match = 1'b1;
        state_nxt      = S_INS_DEC;
      end
      S_INS_DEC: begin
        if (sts.item_over) begin
          goal_nxt  = G_ALL;
          state_nxt = S_EV_SCAN;
        end else if (sts.full) begin
          goal_nxt  = G_FULL;
          state_nxt = S_EV_SCAN;
        end else begin
          state_nxt = S_FREE_SCAN;
        end
      end
      S_FREE_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = sts.ffound;
        state_nxt = S_TRIM_CHK;
      end
      S_TRIM_CHK: begin
        if (sts.over_budget) begin
          goal_nxt  = G_TRIM;
          state_nxt = S_EV_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EV_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_EV_DEC;
      end
      S_EV_DEC: begin
        state_nxt = sts.ofound ? S_EV_EMIT : S_DONE;
      end
      S_EV_EMIT: begin
        if (sts.out_free) begin
          cmd.evict      = 1'b1;
          cmd.emit_evict = 1'b1;
          unique case (goal_r)
            G_ALL:   state_nxt = S_EV_SCAN;
            G_FULL:  state_nxt = S_FREE_SCAN;
            G_TRIM:  state_nxt = S_TRIM_CHK;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/bbl_datapath.sv
module bbl_datapath
  import bbl_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_item_id,
  input  logic [15:0] in_target_size,
  input  logic [31:0] in_item_bytes,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_kind,
  output logic        out_hit,
  output logic [31:0] out_evicted_id,
  output logic [31:0] out_evicted_bytes,
  output logic [39:0] out_total_bytes,
  output logic [5:0]  out_entry_count,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_lookup_count,
  output logic        out_last,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [39:0] budget_r;
  logic [2:0]  mode_r;
  logic [31:0] req_id_r, req_bytes_r;
  logic [15:0] req_tgt_r;

  logic [ENTRIES-1:0] valid_r;
  logic [31:0] slot_id_r    [ENTRIES];
  logic [15:0] slot_tgt_r   [ENTRIES];
  logic [31:0] slot_bytes_r [ENTRIES];
  logic [47:0] slot_stamp_r [ENTRIES];

  logic [47:0] stamp_r;
  logic [39:0] held_r;
  logic [CW-1:0] cnt_r;
  logic [31:0] hits_r, lookups_r;
  logic        hit_r;

  logic [IW-1:0] idx_r;
  logic          mfound_r, ffound_r, ofound_r;
  logic [IW-1:0] midx_r, fidx_r, oidx_r;
  logic [15:0]   mtgt_r;
  logic [31:0]   mbytes_r, oid_r, obytes_r;
  logic [47:0]   ostamp_r;

  logic        out_valid_r, out_kind_r, out_hit_r, out_last_r;
  logic [31:0] out_eid_r, out_eb_r, out_hits_r, out_lookups_r;
  logic [39:0] out_total_r;
  logic [5:0]  out_count_r;

  logic        first, scan_last, m_have, f_have, o_have;
  logic        v_i, m_take, f_take, o_take, lk_hit, out_free;
  logic [47:0] stamp_new;

  assign first     = (idx_r == '0);
  assign scan_last = (idx_r == IW'(ENTRIES - 1));
  assign m_have    = mfound_r && !first;
  assign f_have    = ffound_r && !first;
  assign o_have    = ofound_r && !first;
  assign v_i       = valid_r[idx_r];
  assign m_take    = !m_have && v_i && (slot_id_r[idx_r] == req_id_r);
  assign f_take    = !f_have && !v_i;
  assign o_take    = v_i && (!o_have || (slot_stamp_r[idx_r] < ostamp_r));
  assign lk_hit    = mfound_r && (mtgt_r == req_tgt_r);
  assign stamp_new = stamp_r + 48'd1;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= '0;
      valid_r     <= '0;
      stamp_r     <= '0;
      held_r      <= '0;
      cnt_r       <= '0;
      hits_r      <= '0;
      lookups_r   <= '0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      mfound_r    <= 1'b0;
      ffound_r    <= 1'b0;
      ofound_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) budget_r <= cfg_wdata;
      if (cmd.latch_req) hit_r <= 1'b0;
      if (cmd.scan) begin
        idx_r <= scan_last ? '0 : idx_r + IW'(1);
        if (first) begin
          mfound_r <= m_take;
          ffound_r <= f_take;
          ofound_r <= o_take;
        end else begin
          mfound_r <= mfound_r | m_take;
          ffound_r <= ffound_r | f_take;
          ofound_r <= ofound_r | o_take;
        end
      end
      if (cmd.lk_upd) begin
        if (lookups_r != '1) lookups_r <= lookups_r + 32'd1;
        if (lk_hit) begin
          hit_r   <= 1'b1;
          stamp_r <= stamp_new;
          if (hits_r != '1) hits_r <= hits_r + 32'd1;
        end
      end
      if (cmd.clr_stats) begin
        hits_r    <= '0;
        lookups_r <= '0;
      end
      if (cmd.clear_all) begin
        valid_r <= '0;
        held_r  <= '0;
        cnt_r   <= '0;
      end
      if (cmd.drop_match && mfound_r) begin
        valid_r[midx_r] <= 1'b0;
        held_r          <= held_r - {8'd0, mbytes_r};
        cnt_r           <= cnt_r - CW'(1);
      end
      if (cmd.evict) begin
        valid_r[oidx_r] <= 1'b0;
        held_r          <= held_r - {8'd0, obytes_r};
        cnt_r           <= cnt_r - CW'(1);
      end
      if (cmd.store) begin
        valid_r[fidx_r] <= 1'b1;
        held_r          <= held_r + {8'd0, req_bytes_r};
        cnt_r           <= cnt_r + CW'(1);
        stamp_r         <= stamp_new;
      end
      if (cmd.emit_done || cmd.emit_evict) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      mode_r      <= in_mode;
      req_id_r    <= in_item_id;
      req_tgt_r   <= in_target_size;
      req_bytes_r <= in_item_bytes;
    end
    if (cmd.scan) begin
      if (m_take) begin
        midx_r   <= idx_r;
        mtgt_r   <= slot_tgt_r[idx_r];
        mbytes_r <= slot_bytes_r[idx_r];
      end
      if (f_take) fidx_r <= idx_r;
      if (o_take) begin
        oidx_r   <= idx_r;
        ostamp_r <= slot_stamp_r[idx_r];
        oid_r    <= slot_id_r[idx_r];
        obytes_r <= slot_bytes_r[idx_r];
      end
    end
    if (cmd.lk_upd && lk_hit) slot_stamp_r[midx_r] <= stamp_new;
    if (cmd.store) begin
      slot_id_r[fidx_r]    <= req_id_r;
      slot_tgt_r[fidx_r]   <= req_tgt_r;
      slot_bytes_r[fidx_r] <= req_bytes_r;
      slot_stamp_r[fidx_r] <= stamp_new;
    end
    if (cmd.emit_evict) begin
      out_kind_r    <= 1'b1;
      out_hit_r     <= 1'b0;
      out_eid_r     <= oid_r;
      out_eb_r      <= obytes_r;
      out_total_r   <= held_r - {8'd0, obytes_r};
      out_count_r   <= 6'(cnt_r - CW'(1));
      out_hits_r    <= hits_r;
      out_lookups_r <= lookups_r;
      out_last_r    <= 1'b0;
    end else if (cmd.emit_done) begin
      out_kind_r    <= 1'b0;
      out_hit_r     <= hit_r;
      out_eid_r     <= '0;
      out_eb_r      <= '0;
      out_total_r   <= held_r;
      out_count_r   <= 6'(cnt_r);
      out_hits_r    <= hits_r;
      out_lookups_r <= lookups_r;
      out_last_r    <= 1'b1;
    end
  end

  always_comb begin
    sts.mode        = mode_r;
    sts.scan_last   = scan_last;
    sts.req_invalid = (req_id_r == '0) || (req_tgt_r == '0) || (req_bytes_r == '0);
    sts.item_over   = ({8'd0, req_bytes_r} > budget_r);
    sts.over_budget = (held_r > budget_r);
    sts.full        = (cnt_r == CW'(ENTRIES));
    sts.ffound      = ffound_r;
    sts.ofound      = ofound_r;
    sts.out_free    = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_id    = out_eid_r;
  assign out_evicted_bytes = out_eb_r;
  assign out_total_bytes   = out_total_r;
  assign out_entry_count   = out_count_r;
  assign out_hit_count     = out_hits_r;
  assign out_lookup_count  = out_lookups_r;
  assign out_last          = out_last_r;

endmodule

FILE: sv/byte_budget_lru_cache.sv
// Size-budgeted LRU cache of ENTRIES slots (id, target size, bytes, stamp).
// Input channel in_valid/in_ready carries one request transaction (mode,
// item_id, target_size, item_bytes). Output channel out_valid/out_ready
// returns zero or more eviction reports (kind 1) followed by one completion
// (kind 0, last 1). cfg_we writes the 40-bit byte budget; write it only when
// no request is in progress.
// One request is worked at a time; in_ready is high only when idle, so the
// next request can be taken while the completion still waits for out_ready.
// Every table search is a sequential pass over all ENTRIES slot registers.
// A lookup is a pass and an update. An insert passes for a match and drops
// it, evicts if full, passes for a free slot, stores and trims to the
// budget; a trim evicts while over budget. Each eviction is a pass for the
// oldest entry and a report; an oversized insert evicts every entry and
// ends with one empty pass. Clear, statistics reset, invalid inserts and
// unused modes go straight to the completion. Results leave through an
// output register; a stalled receiver holds bbl_ctrl in its emit state.
// Synchronous reset empties the table, zeroes counters and the budget.
module byte_budget_lru_cache
  import bbl_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_item_id,
  input  logic [15:0] in_target_size,
  input  logic [31:0] in_item_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic        out_hit,
  output logic [31:0] out_evicted_id,
  output logic [31:0] out_evicted_bytes,
  output logic [39:0] out_total_bytes,
  output logic [5:0]  out_entry_count,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_lookup_count,
  output logic        out_last
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbl_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_mode),
    .in_item_id        (in_item_id),
    .in_target_size    (in_target_size),
    .in_item_bytes     (in_item_bytes),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_hit           (out_hit),
    .out_evicted_id    (out_evicted_id),
    .out_evicted_bytes (out_evicted_bytes),
    .out_total_bytes   (out_total_bytes),
    .out_entry_count   (out_entry_count),
    .out_hit_count     (out_hit_count),
    .out_lookup_count  (out_lookup_count),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

  a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |-> sts.ofound) else $error("eviction without a victim");

  a_store_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> sts.ffound) else $error("store without a free slot");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_done, cmd.emit_evict})) else $error("double emit");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_done || cmd.emit_evict) |-> sts.out_free)
    else $error("emit over a held result");

endmodule

FILE: tb/byte_budget_lru_cache_checker.sv
module byte_budget_lru_cache_checker
  import bbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_item_id,
  input  logic [15:0] in_target_size,
  input  logic [31:0] in_item_bytes,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_kind,
  input  logic        out_hit,
  input  logic [31:0] out_evicted_id,
  input  logic [31:0] out_evicted_bytes,
  input  logic [39:0] out_total_bytes,
  input  logic [5:0]  out_entry_count,
  input  logic [31:0] out_hit_count,
  input  logic [31:0] out_lookup_count,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  localparam int SLOTS = 32;
  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        hit;
    logic [31:0] eid;
    logic [31:0] ebytes;
    logic [39:0] total;
    logic [5:0]  count;
    logic [31:0] hits;
    logic [31:0] lookups;
    logic        last;
  } cache_result_t;

  cache_result_t expected_results[$];

  logic        slot_on  [SLOTS];
  logic [31:0] slot_key [SLOTS];
  logic [15:0] slot_tgt [SLOTS];
  logic [31:0] slot_len [SLOTS];
  logic [47:0] slot_age [SLOTS];
  logic [47:0] age_ctr;
  logic [39:0] held;
  logic [39:0] budget;
  logic [31:0] hits;
  logic [31:0] lookups;

  assign pending = expected_results.size();

  task automatic push_result(logic kind, logic hit, logic [31:0] eid, logic [31:0] eb,
                             logic last);
    cache_result_t r;
    int c;
    c = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_on[i]) c++;
    r.kind = kind; r.hit = hit; r.eid = eid; r.ebytes = eb;
    r.total = held; r.count = c[5:0]; r.hits = hits; r.lookups = lookups;
    r.last = last;
    expected_results.push_back(r);
  endtask

  function automatic int oldest_slot();
    int v;
    v = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_on[i] && (v < 0 || slot_age[i] < slot_age[v])) v = i;
    return v;
  endfunction

  task automatic evict_lru(output bit found);
    int v;
    v = oldest_slot();
    found = (v >= 0);
    if (found) begin
      held = held - {8'd0, slot_len[v]};
      slot_on[v] = 1'b0;
      push_result(KIND_EVICT, 1'b0, slot_key[v], slot_len[v], 1'b0);
    end
  endtask

  task automatic trim_to_budget();
    bit f;
    f = 1;
    while (f && held > budget) evict_lru(f);
  endtask

  task automatic predict_insert(logic [31:0] id, logic [15:0] ts, logic [31:0] nb);
    int m;
    int fr;
    bit f;
    m = -1;
    fr = -1;
    if (id == 0 || ts == 0 || nb == 0) return;
    for (int i = 0; i < SLOTS; i++) if (m < 0 && slot_on[i] && slot_key[i] == id) m = i;
    if (m >= 0) begin
      held = held - {8'd0, slot_len[m]};
      slot_on[m] = 1'b0;
    end
    if ({8'd0, nb} > budget) begin
      f = 1;
      while (f) evict_lru(f);
      return;
    end
    for (int i = 0; i < SLOTS; i++) if (fr < 0 && !slot_on[i]) fr = i;
    if (fr < 0) begin
      evict_lru(f);
      for (int i = 0; i < SLOTS; i++) if (fr < 0 && !slot_on[i]) fr = i;
    end
    age_ctr = age_ctr + 48'd1;
    slot_on[fr] = 1'b1; slot_key[fr] = id; slot_tgt[fr] = ts;
    slot_len[fr] = nb; slot_age[fr] = age_ctr;
    held = held + {8'd0, nb};
    trim_to_budget();
  endtask

  task automatic predict_request(logic [2:0] mode, logic [31:0] id, logic [15:0] ts,
                                 logic [31:0] nb);
    logic hit;
    int m;
    hit = 1'b0;
    m = -1;
    case (mode)
      MODE_LOOKUP: begin
        if (lookups != 32'hFFFF_FFFF) lookups++;
        for (int i = 0; i < SLOTS; i++) if (m < 0 && slot_on[i] && slot_key[i] == id) m = i;
        if (m >= 0 && slot_tgt[m] == ts) begin
          hit = 1'b1;
          if (hits != 32'hFFFF_FFFF) hits++;
          age_ctr = age_ctr + 48'd1;
          slot_age[m] = age_ctr;
        end
      end
      MODE_INSERT: predict_insert(id, ts, nb);
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;
        held = '0;
      end
      MODE_STATS: begin
        hits = '0;
        lookups = '0;
      end
      MODE_TRIM: trim_to_budget();
      default: ;
    endcase
    push_result(KIND_DONE, hit, '0, '0, 1'b1);
  endtask

  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t exp;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_on[i] = 1'b0; slot_key[i] = '0; slot_tgt[i] = '0;
        slot_len[i] = '0; slot_age[i] = '0;
      end
      age_ctr = '0; held = '0; budget = '0; hits = '0; lookups = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_kind, out_hit, out_evicted_id, out_evicted_bytes, out_total_bytes,
               out_entry_count, out_hit_count, out_lookup_count, out_last};
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transaction kind=%0d id=%h", $time,
                   out_kind, out_evicted_id);
        end else begin
          exp = expected_results.pop_front();
          if (got !== exp) begin
            fail_count++;
            $display("%0t: mismatch exp kind=%0d hit=%0d id=%h b=%h tot=%h n=%0d hc=%0d lc=%0d last=%0d",
                     $time, exp.kind, exp.hit, exp.eid, exp.ebytes, exp.total, exp.count,
                     exp.hits, exp.lookups, exp.last);
            $display("%0t:          got kind=%0d hit=%0d id=%h b=%h tot=%h n=%0d hc=%0d lc=%0d last=%0d",
                     $time, got.kind, got.hit, got.eid, got.ebytes, got.total, got.count,
                     got.hits, got.lookups, got.last);
          end
        end
      end
      if (cfg_we) budget = cfg_wdata;
      if (in_valid && in_ready)
        predict_request(in_mode, in_item_id, in_target_size, in_item_bytes);
    end
  end

endmodule

FILE: tb/tb_byte_budget_lru_cache.sv
module tb_byte_budget_lru_cache;
  import bbl_pkg::*;

  localparam int LIMIT = 3000000;
  localparam logic [39:0] BUDGET_MAX = 40'hFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [39:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [31:0] in_item_id;
  logic [15:0] in_target_size;
  logic [31:0] in_item_bytes;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic        out_hit;
  logic [31:0] out_evicted_id;
  logic [31:0] out_evicted_bytes;
  logic [39:0] out_total_bytes;
  logic [5:0]  out_entry_count;
  logic [31:0] out_hit_count;
  logic [31:0] out_lookup_count;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          cycles;
  int          burst_left;
  logic        hold_req;
  logic        hold_done;
  logic [39:0] budget_now;

  byte_budget_lru_cache DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_item_id(in_item_id), .in_target_size(in_target_size),
    .in_item_bytes(in_item_bytes), .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_hit(out_hit), .out_evicted_id(out_evicted_id),
    .out_evicted_bytes(out_evicted_bytes), .out_total_bytes(out_total_bytes),
    .out_entry_count(out_entry_count), .out_hit_count(out_hit_count),
    .out_lookup_count(out_lookup_count), .out_last(out_last)
  );

  byte_budget_lru_cache_checker checker_i (.*);

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: ready pattern drawn at random from three kinds; one long hold on request
  initial begin
    int cyc;
    int pat;
    cyc = 0;
    pat = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) pat = $urandom_range(0, 2);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        case (pat)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ((cyc % 7) < 4);
        endcase
      end
    end
  end

  task automatic send(logic [2:0] mode, logic [31:0] id, logic [15:0] ts, logic [31:0] nb);
    in_valid <= 1'b1;
    in_mode <= mode; in_item_id <= id; in_target_size <= ts; in_item_bytes <= nb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 10);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_budget(logic [39:0] b);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    budget_now = b;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [31:0] cap;
    r = $urandom_range(0, 99);
    cap = (budget_now > 40'd8000) ? 32'd2000 : ((budget_now[31:0] >> 2) + 32'd1);
    if (r < 55)
      send(MODE_INSERT, $urandom_range(1, 48), 16'($urandom_range(1, 3)),
           $urandom_range(1, cap));
    else if (r < 80)
      send(MODE_LOOKUP, $urandom_range(0, 48), 16'($urandom_range(1, 3)), $urandom);
    else if (r < 85)
      send(MODE_INSERT, $urandom, 16'($urandom), $urandom);
    else if (r < 88)
      send(MODE_INSERT, $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 48),
           16'($urandom_range(0, 1)), $urandom_range(0, 1) ? 32'd0 : 32'd5);
    else if (r < 91)
      send(MODE_TRIM, $urandom, 16'($urandom), $urandom);
    else if (r < 93)
      send(MODE_CLEAR, $urandom, 16'($urandom), $urandom);
    else if (r < 95)
      send(MODE_STATS, $urandom, 16'($urandom), $urandom);
    else if (r < 97)
      send(3'($urandom_range(5, 7)), $urandom, 16'($urandom), $urandom);
    else
      send(MODE_LOOKUP, $urandom, 16'($urandom), $urandom);
  endtask

  initial begin
    cycles = 0;
    burst_left = 0;
    hold_req = 1'b0;
    budget_now = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; in_mode = MODE_LOOKUP;
    in_item_id = '0; in_target_size = '0; in_item_bytes = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero budget: every valid insert is oversized
    send(MODE_INSERT, 32'd7, 16'd1, 32'd1);
    send(MODE_LOOKUP, 32'd7, 16'd1, 32'd0);
    set_budget(BUDGET_MAX);
    send(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send(MODE_INSERT, 32'd1, 16'd1, 32'hFFFF_FFFF);
    send(MODE_INSERT, 32'd0, 16'd5, 32'd10);
    send(MODE_INSERT, 32'd2, 16'd0, 32'd10);
    send(MODE_INSERT, 32'd3, 16'd5, 32'd0);
    send(MODE_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    send(MODE_LOOKUP, 32'd1, 16'd2, 32'd0);
    send(MODE_LOOKUP, 32'd0, 16'd0, 32'd0);
    send(MODE_INSERT, 32'd1, 16'd9, 32'd100);
    send(MODE_LOOKUP, 32'd1, 16'd9, 32'd0);
    send(3'd5, 32'd1, 16'd1, 32'd1);
    send(3'd7, 32'd1, 16'd1, 32'd1);
    send(MODE_STATS, 32'd0, 16'd0, 32'd0);
    send(MODE_CLEAR, 32'd0, 16'd0, 32'd0);
    // full table
    for (int i = 1; i <= 34; i++) send(MODE_INSERT, i, 16'd1, i * 10);
    set_budget(40'd1000);
    send(MODE_TRIM, 32'd0, 16'd0, 32'd0);
    send(MODE_INSERT, 32'd30, 16'd1, 32'd1001);
    send(MODE_LOOKUP, 32'd30, 16'd1, 32'd0);

    set_budget(BUDGET_MAX);
    hold_req = 1'b1;
    for (int i = 0; i < 50; i++) random_item();
    set_budget(40'd3000);
    for (int i = 0; i < 40; i++) random_item();
    set_budget(40'd0);
    for (int i = 0; i < 15; i++) random_item();
    set_budget({$urandom, 8'($urandom_range(0, 255))});
    for (int i = 0; i < 30; i++) random_item();
    set_budget(40'd200000);
    for (int i = 0; i < 50; i++) random_item();
    send(MODE_TRIM, 32'd0, 16'd0, 32'd0);

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bbl_pkg.sv
sv/bbl_ctrl.sv
sv/bbl_datapath.sv
sv/byte_budget_lru_cache.sv
tb/byte_budget_lru_cache_checker.sv
tb/tb_byte_budget_lru_cache.sv
